FILE: design/cprr_pkg.sv
// shared types, constants and pixel functions for the pie ring clock renderer
// no dependencies; used by every module of the block
`default_nettype none

package cprr_pkg;

    localparam int RING_LEN   = 60;
    localparam int WEDGE_LEN  = 12;
    localparam int SUB_STEPS  = 64;
    localparam int TICK_MAIN  = 32;

    localparam int IN_W  = 24;
    localparam int OUT_W = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_SMOOTH_HANDS = 2'd0;
    localparam logic [1:0] CFG_SHOW_TICKS   = 2'd1;

    // reciprocal constants: s/60 for s < 4096, m/12 for m < 4101
    localparam logic [12:0] RECIP_60 = 13'd4370;
    localparam logic [12:0] RECIP_12 = 13'd5462;

    typedef struct packed {
        logic [5:0] start;
        logic [5:0] frac;
    } hand_t;

    typedef struct packed {
        hand_t red;
        hand_t green;
        hand_t blue;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // start pixel of a hand: (pos / 64) mod 60, pos / 64 stays below 180
    function automatic logic [5:0] start_of(logic [13:0] pos);
        logic [7:0] q;
        logic [7:0] r;
        q = pos[13:6];
        if (q >= 8'd120)
        begin
            r = q - 8'd120;
        end
        else if (q >= 8'd60)
        begin
            r = q - 8'd60;
        end
        else
        begin
            r = q;
        end
        return r[5:0];
    endfunction

    // frac / 3 for frac < 64
    function automatic logic [4:0] div3(logic [5:0] frac);
        logic [11:0] p;
        p = 12'(frac) * 12'd43;
        return p[11:7];
    endfunction

    // level of one channel at ring position idx for a hand
    function automatic logic [7:0] hand_level(hand_t hand, logic [5:0] idx);
        logic [6:0] diff;
        logic [5:0] d;
        logic [5:0] lead;
        logic [7:0] dim;
        logic [7:0] level;
        diff = {1'b0, hand.start} - {1'b0, idx};
        if (diff[6])
        begin
            d = diff[5:0] + 6'd60;
        end
        else
        begin
            d = diff[5:0];
        end
        lead = (hand.start == 6'(RING_LEN - 1)) ? 6'd0 : hand.start + 6'd1;
        dim  = 8'(d) * 8'd21 + 8'(div3(hand.frac));
        if (d < 6'(WEDGE_LEN))
        begin
            level = 8'd255 - dim;
        end
        else if ((hand.frac != 6'd0) && (idx == lead))
        begin
            level = {hand.frac, 2'b00};
        end
        else
        begin
            level = 8'd0;
        end
        return level;
    endfunction

    // saturating quarter-hour tick marks
    function automatic logic [7:0] tick_add(logic [7:0] level, logic [5:0] idx, logic en);
        logic [7:0] add;
        logic [8:0] sum;
        if (!en)
        begin
            add = 8'd0;
        end
        else if (idx == 6'd0)
        begin
            add = 8'(TICK_MAIN);
        end
        else if ((idx == 6'd15) || (idx == 6'd30) || (idx == 6'd45))
        begin
            add = 8'(TICK_MAIN / 4);
        end
        else
        begin
            add = 8'd0;
        end
        sum = {1'b0, level} + {1'b0, add};
        return sum[8] ? 8'd255 : sum[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/clock_pie_ring_renderer.sv
// pie ring clock renderer: one time of day in, sixty ring pixels out
// depends on cprr_pkg, cprr_front, cprr_queue and cprr_back
//
// usage:
//   s_axis carries one time of day per transaction (hour, minute, second,
//   1/64-second fraction). m_axis carries the 60 pixels of the ring face,
//   pixel 0 first, tlast on pixel 59. cfg writes smooth_hands (index 0) and
//   show_ticks (index 1); cfg_ready is always high, write only while idle.
// path: after a time is accepted it passes two more hand position stages,
//   the queue write and the output register before the first pixel is valid.
// throughput: one pixel per cycle while m_axis_tready is high and a frame
//   is queued, set by the single pixel walker in the back part. The front
//   accepts the next times while a frame is still streaming, until the
//   two-entry descriptor queue and its pipeline are full.
// reset: both config registers clear, the pipeline, queue and output empty.
// stall: when m_axis_tready is low the output register holds its pixel and
//   the walker waits; the queue then fills and s_axis_tready drops.
`default_nettype none

module clock_pie_ring_renderer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // hour_value[4:0], minute_value[10:5], second_value[16:11],
    // subsecond_value[22:17], zero[23]
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pixel_index[5:0], red[13:6], green[21:14], blue[29:22], zero[31:30]
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic        cfg_data
);

    logic              smooth_hands_reg;
    logic              show_ticks_reg;
    logic              q_push, q_pop;
    cprr_pkg::frame_t  q_in, q_head;
    cprr_pkg::q_stat_t q_stat;
    logic [5:0]        pixel_index;
    logic [7:0]        red, green, blue;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_hands_reg <= 1'b0;
            show_ticks_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == cprr_pkg::CFG_SMOOTH_HANDS)
            begin
                smooth_hands_reg <= cfg_data;
            end
            if (cfg_index == cprr_pkg::CFG_SHOW_TICKS)
            begin
                show_ticks_reg <= cfg_data;
            end
        end
    end

    cprr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .smooth_hands    (smooth_hands_reg),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .hour_value      (s_axis_tdata[4:0]),
        .minute_value    (s_axis_tdata[10:5]),
        .second_value    (s_axis_tdata[16:11]),
        .subsecond_value (s_axis_tdata[22:17]),
        .q_stat          (q_stat),
        .q_push          (q_push),
        .q_data          (q_in)
    );

    cprr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    cprr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .show_ticks  (show_ticks_reg),
        .head        (q_head),
        .q_stat      (q_stat),
        .pop         (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, blue, green, red, pixel_index};

`ifndef ASSERT_OFF
    // tlast only on the final ring position
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == 6'd59))
        else $error("tlast on a pixel other than the last");

    // pixels of a frame come out in ring order
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (!m_axis_tvalid || (m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1)))
        else $error("pixel index skipped or repeated");

    // queue never written while full, unless it is popped as well
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (!q_stat.full || q_pop))
        else $error("descriptor queue overflow");

    // queue never read while empty
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("descriptor queue underflow");
`endif

endmodule

`default_nettype wire

FILE: design/cprr_front.sv
// front part: accepts a time of day and works out the three hand descriptors
// depends on cprr_pkg; pushes one frame descriptor per time into cprr_queue
`default_nettype none

module cprr_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 smooth_hands,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [4:0]           hour_value,
    input  wire logic [5:0]           minute_value,
    input  wire logic [5:0]           second_value,
    input  wire logic [5:0]           subsecond_value,
    input  wire cprr_pkg::q_stat_t    q_stat,
    output logic                      q_push,
    output cprr_pkg::frame_t          q_data
);

    logic        pipe_en;
    logic        f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic [11:0] f1_s_reg;
    logic [5:0]  f1_min_reg;
    logic [4:0]  f1_hour_reg;
    logic [11:0] f2_s_reg;
    logic [12:0] f2_m_reg;
    logic [4:0]  f2_hour_reg;
    logic [11:0] f3_s_reg;
    logic [12:0] f3_m_reg;
    logic [13:0] f3_h_reg;

    logic [24:0] qs_prod;
    logic [12:0] m_next;
    logic [25:0] qh_prod;
    logic [13:0] h_next;

    assign pipe_en  = !f3_valid_reg || !q_stat.full;
    assign in_ready = pipe_en;
    assign q_push   = f3_valid_reg && !q_stat.full;

    // m = minute*64 + s/60
    assign qs_prod = 25'(f1_s_reg) * 25'(cprr_pkg::RECIP_60);
    assign m_next  = {1'b0, f1_min_reg, 6'd0} + 13'(qs_prod[24:18]);

    // h = 320*hour + m/12
    assign qh_prod = 26'(f2_m_reg) * 26'(cprr_pkg::RECIP_12);
    assign h_next  = {1'b0, f2_hour_reg, 8'd0} + {3'd0, f2_hour_reg, 6'd0}
                   + 14'(qh_prod[25:16]);

    always_comb
    begin
        q_data.red.start   = cprr_pkg::start_of(f3_h_reg);
        q_data.green.start = cprr_pkg::start_of({1'b0, f3_m_reg});
        q_data.blue.start  = cprr_pkg::start_of({2'b00, f3_s_reg});
        q_data.red.frac    = smooth_hands ? f3_h_reg[5:0] : 6'd0;
        q_data.green.frac  = smooth_hands ? f3_m_reg[5:0] : 6'd0;
        q_data.blue.frac   = smooth_hands ? f3_s_reg[5:0] : 6'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            f1_s_reg    <= {second_value, subsecond_value};
            f1_min_reg  <= minute_value;
            f1_hour_reg <= hour_value;
            f2_s_reg    <= f1_s_reg;
            f2_m_reg    <= m_next;
            f2_hour_reg <= f1_hour_reg;
            f3_s_reg    <= f2_s_reg;
            f3_m_reg    <= f2_m_reg;
            f3_h_reg    <= h_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/cprr_queue.sv
// two-entry queue of frame descriptors between front and back parts
// depends on cprr_pkg for the frame and status types
`default_nettype none

module cprr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire cprr_pkg::frame_t  push_data,
    input  wire logic              pop,
    output cprr_pkg::frame_t       head,
    output cprr_pkg::q_stat_t      stat
);

    cprr_pkg::frame_t entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/cprr_back.sv
// back part: walks the ring one pixel per cycle unless stalled, drives the output register
// depends on cprr_pkg; pops one frame descriptor from cprr_queue per 60 pixels
`default_nettype none

module cprr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              show_ticks,
    input  wire cprr_pkg::frame_t  head,
    input  wire cprr_pkg::q_stat_t q_stat,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [5:0]             pixel_index,
    output logic [7:0]             red,
    output logic [7:0]             green,
    output logic [7:0]             blue,
    output logic                   last_pixel
);

    logic       out_valid_reg;
    logic [5:0] cnt_reg, cnt_next;
    logic [5:0] idx_reg;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       last_reg;
    logic       adv, take, at_end;

    assign adv    = !out_valid_reg || out_ready;
    assign take   = adv && !q_stat.empty;
    assign at_end = (cnt_reg == 6'(cprr_pkg::RING_LEN - 1));
    assign pop    = take && at_end;
    assign cnt_next = at_end ? 6'd0 : cnt_reg + 6'd1;

    assign out_valid   = out_valid_reg;
    assign pixel_index = idx_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign last_pixel  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= 6'd0;
        end
        else if (adv)
        begin
            out_valid_reg <= take;
            if (take)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            idx_reg   <= cnt_reg;
            last_reg  <= at_end;
            red_reg   <= cprr_pkg::tick_add(cprr_pkg::hand_level(head.red, cnt_reg),
                                            cnt_reg, show_ticks);
            green_reg <= cprr_pkg::tick_add(cprr_pkg::hand_level(head.green, cnt_reg),
                                            cnt_reg, show_ticks);
            blue_reg  <= cprr_pkg::tick_add(cprr_pkg::hand_level(head.blue, cnt_reg),
                                            cnt_reg, show_ticks);
        end
    end

endmodule

`default_nettype wire

FILE: sim/clock_pie_ring_renderer_tb.sv
// self-checking testbench for clock_pie_ring_renderer: times of day in, 60-pixel ring frames out
// depends on cprr_pkg and the clock_pie_ring_renderer rtl; a local predictor checks every pixel
`default_nettype none

module clock_pie_ring_renderer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [5:0] sub;
    } clock_time_t;

    typedef struct packed {
        logic [5:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_t;

    typedef logic [59:0][7:0] ring_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic        cfg_data = 1'b0;

    clock_time_t times_pending[$];
    pixel_t      ring_pixels_due[$];

    logic smooth_cfg = 1'b0;
    logic ticks_cfg = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   stall_left = 0;
    int   err_count = 0;

    clock_pie_ring_renderer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one hand as a fading wedge behind its start pixel, plus the leading edge
    function automatic ring_t hand_wedge(int unsigned pos);
        ring_t       lvl;
        int unsigned start;
        int unsigned frac;
        int unsigned k;
        lvl = '0;
        start = (pos / cprr_pkg::SUB_STEPS) % cprr_pkg::RING_LEN;
        frac = smooth_cfg ? (pos % cprr_pkg::SUB_STEPS) : 0;
        for (k = 0; k < cprr_pkg::WEDGE_LEN; k++)
        begin
            lvl[(start + cprr_pkg::RING_LEN - k) % cprr_pkg::RING_LEN] =
                8'(255 - (k * (256 / cprr_pkg::WEDGE_LEN)
                          + ((frac * 256) / cprr_pkg::WEDGE_LEN) / cprr_pkg::SUB_STEPS));
        end
        if (frac != 0)
        begin
            lvl[(start + 1) % cprr_pkg::RING_LEN] = 8'(frac * 4);
        end
        return lvl;
    endfunction

    function automatic logic [7:0] tick_sat(logic [7:0] level, int unsigned add);
        int unsigned sum;
        sum = level + add;
        return (sum > 255) ? 8'd255 : 8'(sum);
    endfunction

    // full frame for one time of day, appended to the pixels due
    function automatic void render_ring(clock_time_t t);
        ring_t       red;
        ring_t       green;
        ring_t       blue;
        int unsigned s;
        int unsigned m;
        int unsigned h;
        int unsigned i;
        int unsigned add;
        pixel_t      px;
        s = t.second * cprr_pkg::SUB_STEPS + t.sub;
        m = t.minute * cprr_pkg::SUB_STEPS + s / 60;
        h = 5 * t.hour * cprr_pkg::SUB_STEPS + (5 * m) / 60;
        red = hand_wedge(h);
        green = hand_wedge(m);
        blue = hand_wedge(s);
        if (ticks_cfg)
        begin
            for (i = 0; i < cprr_pkg::RING_LEN; i += 15)
            begin
                add = (i == 0) ? cprr_pkg::TICK_MAIN : cprr_pkg::TICK_MAIN / 4;
                red[i] = tick_sat(red[i], add);
                green[i] = tick_sat(green[i], add);
                blue[i] = tick_sat(blue[i], add);
            end
        end
        for (i = 0; i < cprr_pkg::RING_LEN; i++)
        begin
            px.idx = 6'(i);
            px.red = red[i];
            px.green = green[i];
            px.blue = blue[i];
            px.last = (i == cprr_pkg::RING_LEN - 1);
            ring_pixels_due.push_back(px);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // sender: holds a transaction until accepted, predicts the frame on acceptance
    always @(posedge clk)
    begin : sender
        clock_time_t t;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                t = times_pending.pop_front();
                render_ring(t);
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                s_axis_tvalid <= 1'b1;
            end
            else if ((times_pending.size() != 0) &&
                     ($urandom_range(0, 99) >= send_idle_pct))
            begin
                t = times_pending[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {1'b0, t.sub, t.second, t.minute, t.hour};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, started by bumping hold_req
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            stall_left <= 400;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
    end

    // receiver: checks each pixel transaction against the oldest one due
    always @(posedge clk)
    begin : receiver
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.idx = m_axis_tdata[5:0];
                got.red = m_axis_tdata[13:6];
                got.green = m_axis_tdata[21:14];
                got.blue = m_axis_tdata[29:22];
                got.last = m_axis_tlast;
                if (ring_pixels_due.size() == 0)
                begin
                    report_mismatch("pixel with nothing due, index", got.idx, -1);
                end
                else
                begin
                    want = ring_pixels_due.pop_front();
                    if (got.idx !== want.idx)
                        report_mismatch("pixel_index", got.idx, want.idx);
                    if (got.red !== want.red)
                        report_mismatch("red", got.red, want.red);
                    if (got.green !== want.green)
                        report_mismatch("green", got.green, want.green);
                    if (got.blue !== want.blue)
                        report_mismatch("blue", got.blue, want.blue);
                    if (got.last !== want.last)
                        report_mismatch("last_pixel", got.last, want.last);
                end
            end
            m_axis_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == cprr_pkg::CFG_SMOOTH_HANDS)
            smooth_cfg = val;
        else
            ticks_cfg = val;
    endtask

    task automatic set_phase(logic smooth, logic ticks, int send_pct, int recv_pct);
        write_reg(cprr_pkg::CFG_SMOOTH_HANDS, smooth);
        write_reg(cprr_pkg::CFG_SHOW_TICKS, ticks);
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic void push_time(int h, int m, int s, int f);
        clock_time_t t;
        t.hour = 5'(h);
        t.minute = 6'(m);
        t.second = 6'(s);
        t.sub = 6'(f);
        times_pending.push_back(t);
    endfunction

    task automatic queue_directed();
        @(negedge clk);
        push_time(0, 0, 0, 0);       // all hands at the top, ticks saturate
        push_time(31, 63, 63, 63);   // every field at its maximum
        push_time(23, 59, 59, 63);   // last instant of the day
        push_time(12, 0, 0, 0);      // hour wraps around the ring
        push_time(0, 0, 59, 1);      // leading edge wraps to pixel 0
        push_time(0, 0, 5, 32);      // wedge wraps backwards past the top
        push_time(11, 30, 14, 32);   // leading edge on a tick pixel
        push_time(6, 15, 30, 0);
        push_time(24, 0, 0, 1);      // hour past the end of the day
        push_time(3, 60, 0, 0);      // minute out of range
        push_time(9, 45, 45, 63);
        push_time(17, 42, 7, 21);
    endtask

    task automatic queue_random(int count);
        int n;
        int h;
        int m;
        int s;
        @(negedge clk);
        for (n = 0; n < count; n++)
        begin
            h = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 23) : $urandom_range(0, 31);
            m = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(0, 63);
            s = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(0, 63);
            push_time(h, m, s, $urandom_range(0, 63));
        end
    endtask

    // wait for every frame to be out, then let the pipeline settle
    task automatic drain();
        while ((times_pending.size() != 0) || (ring_pixels_due.size() != 0))
            @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        set_phase(1'b0, 1'b0, 0, 0);
        queue_directed();
        drain();
        set_phase(1'b1, 1'b1, 0, 0);
        queue_directed();
        drain();

        set_phase(1'b1, 1'b0, 0, 0);
        queue_random(30);
        drain();
        set_phase(1'b0, 1'b1, 48, 0);
        queue_random(30);
        drain();
        set_phase(1'b1, 1'b1, 0, 48);
        queue_random(30);
        drain();
        set_phase(1'b1, 1'b0, 24, 24);
        queue_random(30);
        drain();

        // receiver holds off while the sender keeps offering, input backs up
        set_phase(1'b1, 1'b1, 0, 0);
        hold_req++;
        queue_random(30);
        drain();

        set_phase(1'b0, 1'b0, 48, 0);
        queue_random(30);
        drain();
        set_phase(1'b0, 1'b1, 0, 48);
        queue_random(30);
        drain();
        set_phase(1'b1, 1'b1, 24, 24);
        queue_random(30);
        drain();

        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: clock_pie_ring_renderer.f
design/cprr_pkg.sv
design/cprr_front.sv
design/cprr_queue.sv
design/cprr_back.sv
design/clock_pie_ring_renderer.sv
sim/clock_pie_ring_renderer_tb.sv
